// ===== rtl/core/dspadpcm_pkg.sv =====
// dspadpcm_pkg: types and fixed constants of the dsp adpcm decoder
// no dependencies; used by the top level, front, queue and back end modules

package dspadpcm_pkg;

    // coefficient register file
    localparam int NUM_COEF   = 8;
    localparam int COEF_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // operation codes on the input channel
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_START = 1'b1;

    // sample arithmetic
    localparam int FRAC_BITS  = 11;
    localparam int ACC_W      = 34;
    localparam int Q_W        = ACC_W - FRAC_BITS;
    localparam int ROUND_BIAS = 1024;
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(32767);
    localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(32768);
    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

    // work kinds handed from front to back
    typedef enum logic
    {
        KIND_LOAD,
        KIND_DECODE
    } entry_kind_t;

    typedef struct packed
    {
        entry_kind_t        kind;
        logic [7:0]         header;
        logic signed [15:0] newer;
        logic signed [15:0] older;
        logic [7:0]         data;
        logic               do_high;
        logic               do_low;
        logic               mark_last;
    } queue_entry_t;

    typedef struct packed
    {
        logic                  we;
        logic [COEF_IDX_W-1:0] index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_write_t;

endpackage

// ===== rtl/core/dspadpcm_if.sv =====
// dspadpcm_if: valid/ready channel interfaces for stream bytes and pcm samples
// depends on nothing but plain logic types

interface dspadpcm_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [7:0]         data_byte;
    logic signed [15:0] history_newer;
    logic signed [15:0] history_older;
    logic [2:0]         start_position;
    logic               skip_high;
    logic               stop_after_high;
    logic               last_byte;

    modport source
    (
        output valid, operation, data_byte, history_newer, history_older,
               start_position, skip_high, stop_after_high, last_byte,
        input  ready
    );

    modport sink
    (
        input  valid, operation, data_byte, history_newer, history_older,
               start_position, skip_high, stop_after_high, last_byte,
        output ready
    );
endinterface

interface dspadpcm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               last;

    modport source
    (
        output valid, sample, last,
        input  ready
    );

    modport sink
    (
        input  valid, sample, last,
        output ready
    );
endinterface

// ===== rtl/core/dsp_adpcm_decoder_unit.sv =====
// dsp_adpcm_decoder_unit: top level of the 4-bit dsp adpcm decoder
// depends on dspadpcm_pkg, dspadpcm_if, dspadpcm_front, dspadpcm_queue, dspadpcm_back
//
//   channel   direction  handshake           beat carries
//   stream    in         valid / ready       one stream byte or a start item
//   pcm       out        valid / ready       one 16-bit sample with last flag
//   cfg       in         cfg_we (no stall)   one coefficient pair write
//
// the predictor makes one sample at a time; a two-sample byte holds the queue head
// until its second sample; a start only loads history, header bytes never reach the
// back end, and the multiply-accumulate, fed by its own history, sets the rate; a
// beat's first sample passes the queue slot, then the output register, before it
// shows on pcm; the work queue holds QUEUE_DEPTH entries, so the input takes that
// many work beats while the output is stalled, then ready drops until the back end
// pops; reset clears history, frame position, header, coefficients and the queue

module dsp_adpcm_decoder_unit
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_we,
    input  logic [dspadpcm_pkg::COEF_IDX_W-1:0]      cfg_index,
    input  logic [dspadpcm_pkg::CFG_DATA_W-1:0]      cfg_data,
    dspadpcm_in_if.sink                              stream,
    dspadpcm_out_if.source                           pcm
);

    dspadpcm_pkg::cfg_write_t   cfg;
    dspadpcm_pkg::queue_entry_t push_entry;
    dspadpcm_pkg::queue_entry_t head_entry;
    logic                       push;
    logic                       q_full;
    logic                       pop;
    logic                       head_valid;

    // bundle the configuration write
    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    dspadpcm_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    dspadpcm_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    dspadpcm_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .pcm        (pcm)
    );

endmodule

// ===== rtl/core/dspadpcm_front.sv =====
// dspadpcm_front: accepts stream beats, tracks frame position and header
// depends on dspadpcm_pkg and dspadpcm_in_if

module dspadpcm_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    dspadpcm_in_if.sink                stream,
    input  logic                       q_full,
    output logic                       push,
    output dspadpcm_pkg::queue_entry_t push_entry
);

    logic [2:0] pos_reg;
    logic [2:0] pos_next;
    logic [7:0] header_reg;
    logic [7:0] header_next;
    logic       accept;
    logic       is_start;
    logic       is_header;
    logic       has_sample;

    // take a beat whenever the queue has room
    assign stream.ready = !q_full;
    assign accept       = stream.valid && !q_full;
    assign is_start     = (stream.operation == dspadpcm_pkg::OP_START);
    assign is_header    = !is_start && (pos_reg == 3'd0);
    assign has_sample   = !stream.skip_high || !stream.stop_after_high;

    // only starts and sample-bearing bytes reach the back end
    assign push = accept && (is_start || (!is_header && has_sample));

    // classify the beat into a queue entry
    always_comb
    begin
        push_entry.kind      = is_start ? dspadpcm_pkg::KIND_LOAD
                                        : dspadpcm_pkg::KIND_DECODE;
        push_entry.header    = header_reg;
        push_entry.newer     = stream.history_newer;
        push_entry.older     = stream.history_older;
        push_entry.data      = stream.data_byte;
        push_entry.do_high   = !stream.skip_high;
        push_entry.do_low    = !stream.stop_after_high;
        push_entry.mark_last = stream.last_byte || stream.stop_after_high;
    end

    // frame position and header tracking
    always_comb
    begin
        pos_next    = pos_reg;
        header_next = header_reg;
        if (accept)
        begin
            if (is_start)
            begin
                pos_next    = stream.start_position;
                header_next = stream.data_byte;
            end
            else
            begin
                pos_next = pos_reg + 3'd1;
                if (is_header)
                begin
                    header_next = stream.data_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 3'd0;
            header_reg <= 8'd0;
        end
        else
        begin
            pos_reg    <= pos_next;
            header_reg <= header_next;
        end
    end

endmodule

// ===== rtl/core/dspadpcm_queue.sv =====
// dspadpcm_queue: short fifo of work entries between front and back end
// depends on dspadpcm_pkg

module dspadpcm_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  dspadpcm_pkg::queue_entry_t push_entry,
    output logic                       full,
    input  logic                       pop,
    output logic                       head_valid,
    output dspadpcm_pkg::queue_entry_t head_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dspadpcm_pkg::queue_entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/core/dspadpcm_back.sv =====
// dspadpcm_back: coefficient registers, history and a predictor making one sample
// per cycle unless pcm stalls; depends on dspadpcm_pkg and dspadpcm_out_if

module dspadpcm_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  dspadpcm_pkg::cfg_write_t   cfg,
    input  logic                       head_valid,
    input  dspadpcm_pkg::queue_entry_t head_entry,
    output logic                       pop,
    dspadpcm_out_if.source             pcm
);

    logic [dspadpcm_pkg::CFG_DATA_W-1:0] coef_reg [dspadpcm_pkg::NUM_COEF];
    logic signed [15:0] newer_reg;
    logic signed [15:0] newer_next;
    logic signed [15:0] older_reg;
    logic signed [15:0] older_next;
    logic               phase_reg;
    logic               phase_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [15:0] out_sample_reg;
    logic               out_last_reg;

    logic [dspadpcm_pkg::CFG_DATA_W-1:0] pair;
    logic signed [15:0] c0;
    logic signed [15:0] c1;
    logic               nib_high;
    logic [3:0]         nibble;
    logic signed [3:0]  nib_s;
    logic               final_sample;
    logic               can_emit;
    logic               fire_load;
    logic               fire_decode;
    logic [4:0]         shift_amt;
    logic signed [31:0] prod0;
    logic signed [31:0] prod1;
    logic signed [dspadpcm_pkg::ACC_W-1:0] scaled;
    logic signed [dspadpcm_pkg::ACC_W-1:0] acc;
    logic signed [dspadpcm_pkg::Q_W-1:0]   quot;
    logic signed [15:0] sat;

    // coefficient register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dspadpcm_pkg::NUM_COEF; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg.we)
        begin
            coef_reg[cfg.index] <= cfg.data;
        end
    end

    // nibble selection and handshake with the output register
    assign pair         = coef_reg[head_entry.header[6:4]];
    assign c0           = $signed(pair[15:0]);
    assign c1           = $signed(pair[31:16]);
    assign nib_high     = head_entry.do_high && !phase_reg;
    assign nibble       = nib_high ? head_entry.data[7:4] : head_entry.data[3:0];
    assign nib_s        = $signed(nibble);
    assign final_sample = !nib_high || !head_entry.do_low;
    assign can_emit     = !out_valid_reg || pcm.ready;
    assign fire_load    = head_valid && (head_entry.kind == dspadpcm_pkg::KIND_LOAD);
    assign fire_decode  = head_valid && (head_entry.kind == dspadpcm_pkg::KIND_DECODE)
                          && can_emit;
    assign pop          = fire_load || (fire_decode && final_sample);

    // predictor: scaled nibble plus rounding plus two coefficient products
    assign shift_amt = {1'b0, head_entry.header[3:0]} + 5'(dspadpcm_pkg::FRAC_BITS);
    assign prod0     = c0 * newer_reg;
    assign prod1     = c1 * older_reg;
    assign scaled    = dspadpcm_pkg::ACC_W'(nib_s) <<< shift_amt;
    assign acc       = scaled
                       + dspadpcm_pkg::ACC_W'(dspadpcm_pkg::ROUND_BIAS)
                       + dspadpcm_pkg::ACC_W'(prod0)
                       + dspadpcm_pkg::ACC_W'(prod1);
    assign quot      = $signed(acc[dspadpcm_pkg::ACC_W-1:dspadpcm_pkg::FRAC_BITS]);

    // saturate to 16 bits
    always_comb
    begin
        if (quot > dspadpcm_pkg::Q_MAX)
        begin
            sat = dspadpcm_pkg::SAMPLE_MAX;
        end
        else if (quot < dspadpcm_pkg::Q_MIN)
        begin
            sat = dspadpcm_pkg::SAMPLE_MIN;
        end
        else
        begin
            sat = quot[15:0];
        end
    end

    // history, nibble phase and output valid
    always_comb
    begin
        newer_next     = newer_reg;
        older_next     = older_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !pcm.ready;
        if (fire_load)
        begin
            newer_next = head_entry.newer;
            older_next = head_entry.older;
        end
        else if (fire_decode)
        begin
            newer_next     = sat;
            older_next     = newer_reg;
            phase_next     = !final_sample;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newer_reg     <= '0;
            older_reg     <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            newer_reg     <= newer_next;
            older_reg     <= older_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        if (fire_decode)
        begin
            out_sample_reg <= sat;
            out_last_reg   <= head_entry.mark_last && final_sample;
        end
    end

    assign pcm.valid  = out_valid_reg;
    assign pcm.sample = out_sample_reg;
    assign pcm.last   = out_last_reg;

endmodule

// ===== rtl/core/dspadpcm_checker.sv =====
// dspadpcm_checker: port-level assertions for the dsp adpcm decoder
// bound to dsp_adpcm_decoder_unit; depends on its channel ports only

module dspadpcm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_sample,
    input logic        out_last
);

    // quiet outputs and an open input while held in reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> (!out_valid && in_ready))
        else $error("outputs not quiet during reset");

    // a stalled sample holds its beat
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_sample) && $stable(out_last)))
        else $error("stalled pcm beat changed");

    // a full queue with an idle output drains or emits by the next cycle
    a_full_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_ready && !out_valid) |=> (in_ready || out_valid))
        else $error("back end made no progress on a full queue");

    // an offered beat is not held off for long while the output is idle
    a_ready_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_ready && !out_valid) |=> (in_ready || out_valid))
        else $error("input stalled while the output was idle");

endmodule

bind dsp_adpcm_decoder_unit dspadpcm_checker u_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (stream.valid),
    .in_ready   (stream.ready),
    .out_valid  (pcm.valid),
    .out_ready  (pcm.ready),
    .out_sample (pcm.sample),
    .out_last   (pcm.last)
);
